### sv/sfrx_pkg.sv
// Shared types, codes and constants for the serial frame receiver.
// No dependencies; every other file of the block imports this package.
package sfrx_pkg;

   // Width of the idle tick counter and its largest value.
   localparam int TIMER_BITS = 24;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
   // Compare width that holds any timer value, any timeout register value, plus one.
   localparam int CMP_W = ((TIMER_BITS > 24) ? TIMER_BITS : 24) + 1;

   localparam int TIMEOUT_W = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0]           HEADER_FIRST_RESET  = 8'h5A;
   localparam logic [7:0]           HEADER_SECOND_RESET = 8'hA5;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET       = 24'd10000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

   // Input commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Frame status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_ZERO_LEN = 2'd2;
   localparam logic [1:0] ST_TIMEOUT  = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic [7:0]           header_first;
      logic [7:0]           header_second;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       command;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [15:0] frame_length;
      logic        last;
   } rsp_type;

   // Effective tick limit: register value capped at the timer's range.
   function automatic logic [CMP_W-1:0] timer_limit(input logic [TIMEOUT_W-1:0] ticks);
      logic [CMP_W-1:0] t;
      logic [CMP_W-1:0] m;
      t = CMP_W'(ticks);
      m = CMP_W'(TIMER_MAX);
      return (t > m) ? m : t;
   endfunction

endpackage

### sv/sfrx_if.sv
// Channel interfaces of the serial frame receiver: input, result and register write.
// Depends on sfrx_pkg for widths.
interface sfrx_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] byte_value;

   modport source (output valid, output command, output byte_value, input ready);
   modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface sfrx_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic [15:0] frame_length;
   logic        last;

   modport source (output valid, output out_kind, output payload_byte, output status,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input out_kind, input payload_byte, input status,
                   input frame_length, input last, output ready);
endinterface

interface sfrx_csr_if;
   import sfrx_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TIMEOUT_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### sv/sfrx_csr.sv
// Configuration registers of the serial frame receiver (sync bytes, timeout).
// Depends on sfrx_pkg.
module sfrx_csr
   import sfrx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [TIMEOUT_W-1:0] wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_HEADER_FIRST:  cfg_in.header_first  = wr_data[7:0];
            REG_HEADER_SECOND: cfg_in.header_second = wr_data[7:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= HEADER_FIRST_RESET;
         cfg_ff.header_second <= HEADER_SECOND_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/sfrx_deframe.sv
// Frame state machine: sync hunt, length, payload with running XOR, check, timeout.
// Depends on sfrx_pkg.
module sfrx_deframe
   import sfrx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output logic    emit,
   output rsp_type result
);

   phase_type             phase_ff, phase_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic                  held_valid_ff, held_valid_in;
   logic [15:0]           plen_ff, plen_in;
   logic [15:0]           count_ff, count_in;
   logic [7:0]            xor_ff, xor_in;
   logic [TIMER_BITS-1:0] idle_ff, idle_in;

   logic        is_tick;
   logic        timeout_hit;
   logic        sync_hit;
   logic [15:0] len_full;
   logic [15:0] count_inc;

   assign is_tick     = (req.command == CMD_TICK);
   assign timeout_hit = (CMP_W'(idle_ff) + CMP_W'(1)) >= timer_limit(cfg.timeout_ticks);
   assign sync_hit    = held_valid_ff && (held_byte_ff == cfg.header_first)
                        && (req.byte_value == cfg.header_second);
   assign len_full    = {req.byte_value, plen_ff[7:0]};
   assign count_inc   = count_ff + 16'd1;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (is_tick) begin
            if (phase_ff != PH_HUNT && timeout_hit) phase_in = PH_HUNT;
         end else begin
            case (phase_ff)
               PH_HUNT:    if (sync_hit) phase_in = PH_LEN_LO;
               PH_LEN_LO:  phase_in = PH_LEN_HI;
               PH_LEN_HI:  phase_in = (len_full == 16'd0) ? PH_HUNT : PH_PAYLOAD;
               PH_PAYLOAD: if (count_inc >= plen_ff) phase_in = PH_CHECK;
               PH_CHECK:   phase_in = PH_HUNT;
               default:    phase_in = PH_HUNT;
            endcase
         end
      end
   end

   // Datapath registers and result
   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      plen_in       = plen_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      idle_in       = idle_ff;
      emit          = 1'b0;
      result        = '0;
      if (step) begin
         if (is_tick) begin
            if (phase_ff != PH_HUNT) begin
               if (timeout_hit) begin
                  emit                = 1'b1;
                  result.out_kind     = KIND_STATUS;
                  result.status       = ST_TIMEOUT;
                  result.last         = 1'b1;
                  result.frame_length = (phase_ff == PH_PAYLOAD || phase_ff == PH_CHECK)
                                        ? plen_ff : 16'd0;
                  held_byte_in  = '0;
                  held_valid_in = 1'b0;
                  plen_in       = '0;
                  count_in      = '0;
                  xor_in        = '0;
                  idle_in       = '0;
               end else begin
                  idle_in = idle_ff + TIMER_BITS'(1);
               end
            end
         end else begin
            idle_in = '0;
            case (phase_ff)
               PH_HUNT: begin
                  if (sync_hit) begin
                     held_valid_in = 1'b0;
                     held_byte_in  = '0;
                     plen_in       = '0;
                  end else begin
                     held_byte_in  = req.byte_value;
                     held_valid_in = 1'b1;
                  end
               end
               PH_LEN_LO: plen_in = {8'd0, req.byte_value};
               PH_LEN_HI: begin
                  if (len_full == 16'd0) begin
                     emit                = 1'b1;
                     result.out_kind     = KIND_STATUS;
                     result.status       = ST_ZERO_LEN;
                     result.last         = 1'b1;
                     held_byte_in  = '0;
                     held_valid_in = 1'b0;
                     plen_in       = '0;
                     count_in      = '0;
                     xor_in        = '0;
                  end else begin
                     plen_in  = len_full;
                     count_in = '0;
                     xor_in   = '0;
                  end
               end
               PH_PAYLOAD: begin
                  xor_in              = xor_ff ^ req.byte_value;
                  count_in            = count_inc;
                  emit                = 1'b1;
                  result.out_kind     = KIND_PAYLOAD;
                  result.payload_byte = req.byte_value;
                  result.status       = ST_OK;
                  result.frame_length = plen_ff;
               end
               PH_CHECK: begin
                  emit                = 1'b1;
                  result.out_kind     = KIND_STATUS;
                  result.status       = (req.byte_value == xor_ff) ? ST_OK : ST_MISMATCH;
                  result.frame_length = plen_ff;
                  result.last         = 1'b1;
                  held_byte_in  = '0;
                  held_valid_in = 1'b0;
                  plen_in       = '0;
                  count_in      = '0;
                  xor_in        = '0;
               end
               default: begin
                  held_byte_in  = '0;
                  held_valid_in = 1'b0;
                  plen_in       = '0;
                  count_in      = '0;
                  xor_in        = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         plen_ff       <= '0;
         count_ff      <= '0;
         xor_ff        <= '0;
         idle_ff       <= '0;
      end else begin
         phase_ff      <= phase_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         plen_ff       <= plen_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
         idle_ff       <= idle_in;
      end
   end

endmodule

### sv/sfrx_out.sv
// Result register of the serial frame receiver; holds one beat until taken.
// Depends on sfrx_pkg.
module sfrx_out
   import sfrx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type out_data,
   output logic    has_room
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Room when empty or when the held beat leaves this cycle.
   assign has_room = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### sv/serial_frame_receiver_xor_core.sv
// Top level of the serial frame receiver with XOR checksum.
// Depends on sfrx_pkg, sfrx_if, sfrx_csr, sfrx_deframe and sfrx_out.
//
// Deframes a byte stream of the form sync1 sync2 len_lo len_hi payload[len] check.
// Each req_ beat is either a received byte or one idle tick. While hunting, a
// two-byte sliding window looks for the sync pair; then a 16-bit little-endian
// length follows, each payload byte is forwarded as an rsp_ beat (out_kind 0)
// while a running XOR is kept, and the check byte closes the frame with a status
// beat (out_kind 1, last 1): ok, checksum mismatch, zero length (right after the
// length bytes) or timeout (idle ticks reaching timeout_ticks, zero acting as
// one; ticks are ignored while hunting). After any status the receiver hunts
// again. Drop the payload of a frame whose status is not ok. Every item is
// handled by the frame state machine and lands in a single result register,
// so a beat is accepted every cycle as long as the result register is empty
// or its beat is being taken in the same cycle; req_bus.ready therefore
// follows rsp_bus.ready combinationally. The result of an accepted beat is
// registered and shown on rsp_ in the following cycle. Register writes are
// taken every cycle and take effect once registered; write them only while
// the receiver is idle. Indexes beyond the register list are ignored.
module serial_frame_receiver_xor_core
   import sfrx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sfrx_req_if.sink   req_bus,
   sfrx_rsp_if.source rsp_bus,
   sfrx_csr_if.sink   csr_bus
);

   cfg_type cfg;
   req_type req;
   rsp_type result;
   rsp_type out_data;
   logic    emit;
   logic    has_room;
   logic    step;

   // Registers are always writable.
   assign csr_bus.ready = 1'b1;

   sfrx_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   // Accept a beat whenever the result register can take what it may produce.
   assign req_bus.ready = has_room;
   assign step          = req_bus.valid && has_room;
   assign req.command   = req_bus.command;
   assign req.byte_value = req_bus.byte_value;

   sfrx_deframe u_deframe (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (req),
      .cfg    (cfg),
      .emit   (emit),
      .result (result)
   );

   sfrx_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_data  (out_data),
      .has_room  (has_room)
   );

   assign rsp_bus.out_kind     = out_data.out_kind;
   assign rsp_bus.payload_byte = out_data.payload_byte;
   assign rsp_bus.status       = out_data.status;
   assign rsp_bus.frame_length = out_data.frame_length;
   assign rsp_bus.last         = out_data.last;

endmodule

### sv/sfrx_checker.sv
// Port-level checks for the serial frame receiver, bound to the top level.
// Depends on sfrx_pkg and serial_frame_receiver_xor_core.
module sfrx_checker
   import sfrx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        out_kind,
   input logic [7:0]  payload_byte,
   input logic [1:0]  status,
   input logic [15:0] frame_length,
   input logic        last
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({out_kind, payload_byte, status,
                                                        frame_length, last}))
      else $error("result beat changed while stalled");

   // Status beats and only status beats close a frame.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last == out_kind))
      else $error("last flag disagrees with beat kind");

   // Payload beats carry ok status and a nonzero length.
   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == KIND_PAYLOAD |-> status == ST_OK && frame_length != 16'd0)
      else $error("payload beat with bad status or length");

   // Status beats carry no byte; zero-length status reports length zero.
   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == KIND_STATUS |->
         payload_byte == 8'd0 && (status != ST_ZERO_LEN || frame_length == 16'd0))
      else $error("status beat fields inconsistent");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind serial_frame_receiver_xor_core sfrx_checker u_sfrx_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .out_kind     (rsp_bus.out_kind),
   .payload_byte (rsp_bus.payload_byte),
   .status       (rsp_bus.status),
   .frame_length (rsp_bus.frame_length),
   .last         (rsp_bus.last)
);

### tb/tb.sv
// Self-checking testbench for serial_frame_receiver_xor_core: sync hunting, length,
// XOR check and timeouts. Drives req_, csr_ and rsp_ channels and predicts every result beat.
// Depends on sfrx_pkg, sfrx_if and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfrx_pkg::*;

   // Register index past the end of the list; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   // Idle styles for either side of the block.
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_FULL   = 1;
   localparam int IDLE_SPARSE = 2;

   localparam int  ITEM_TARGET    = 750;
   localparam int  PHASE_ITEMS    = 120;
   localparam int  HOLDOFF_CYCLES = 300;
   localparam int  SETTLE_CYCLES  = 4;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct {
      logic        command;
      logic [7:0]  value;
      int unsigned gap;
   } beat_type;

   logic clock;
   logic reset;

   sfrx_req_if req_bus ();
   sfrx_rsp_if rsp_bus ();
   sfrx_csr_if csr_bus ();

   serial_frame_receiver_xor_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Byte stream waiting to be sent, and result beats the deframer owes us.
   beat_type line_queue[$];
   rsp_type  due_beats[$];

   // Deframer state as predicted by the testbench.
   cfg_type               fr_cfg;
   phase_type             fr_phase;
   logic [7:0]            fr_held;
   logic                  fr_held_ok;
   logic [15:0]           fr_len;
   logic [15:0]           fr_count;
   logic [7:0]            fr_xor;
   logic [TIMER_BITS-1:0] fr_idle;

   beat_type    next_beat;
   beat_type    on_bus;
   logic        staged;
   int unsigned rx_wait;
   int unsigned tx_mode;
   int unsigned rx_mode;
   int          holdoff_left;
   int          holdoff_done;
   int          holdoff_reqs = 0;

   int     errors = 0;
   int     beats_in = 0;
   int     results_seen = 0;
   int     payload_seen = 0;
   int     stim_total = 0;
   int     settings_used = 0;
   int     status_seen[4] = '{0, 0, 0, 0};
   longint cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Drop the frame in progress and go back to looking for the sync pair.
   function automatic void back_to_hunt();
      fr_phase   = PH_HUNT;
      fr_held    = '0;
      fr_held_ok = 1'b0;
      fr_len     = '0;
      fr_count   = '0;
      fr_xor     = '0;
      fr_idle    = '0;
   endfunction

   function automatic rsp_type status_beat(input logic [1:0] code, input logic [15:0] len);
      rsp_type r;
      r = '0;
      r.out_kind     = KIND_STATUS;
      r.status       = code;
      r.frame_length = len;
      r.last         = 1'b1;
      return r;
   endfunction

   // Advance the predicted deframer by one accepted input beat.
   task automatic deframe_step(input logic cmd, input logic [7:0] b);
      longint  lim;
      rsp_type r;
      if (cmd == CMD_TICK) begin
         // Ticks only matter while a frame is under way.
         if (fr_phase == PH_HUNT)
            return;
         // A zero register acts as one: 0 + 1 >= 0 expires on the first tick.
         lim = longint'(fr_cfg.timeout_ticks);
         if (lim > longint'(TIMER_MAX))
            lim = longint'(TIMER_MAX);
         if (longint'(fr_idle) + 1 >= lim) begin
            // Length is only known once both length bytes are in.
            due_beats.push_back(status_beat(ST_TIMEOUT,
               (fr_phase == PH_PAYLOAD || fr_phase == PH_CHECK) ? fr_len : 16'd0));
            back_to_hunt();
         end else begin
            fr_idle = fr_idle + 1'b1;
         end
         return;
      end
      // Any byte restarts the idle count.
      fr_idle = '0;
      case (fr_phase)
         PH_HUNT: begin
            // Two-byte sliding window; equal sync bytes match on the second of a run.
            if (fr_held_ok && fr_held == fr_cfg.header_first && b == fr_cfg.header_second) begin
               fr_held    = '0;
               fr_held_ok = 1'b0;
               fr_len     = '0;
               fr_phase   = PH_LEN_LO;
            end else begin
               fr_held    = b;
               fr_held_ok = 1'b1;
            end
         end
         PH_LEN_LO: begin
            fr_len   = {8'h00, b};
            fr_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            fr_len[15:8] = b;
            if (fr_len == 16'd0) begin
               // Zero length ends the frame at once; no check byte follows.
               due_beats.push_back(status_beat(ST_ZERO_LEN, 16'd0));
               back_to_hunt();
            end else begin
               fr_count = '0;
               fr_xor   = '0;
               fr_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            fr_xor   = fr_xor ^ b;
            fr_count = fr_count + 16'd1;
            if (fr_count >= fr_len)
               fr_phase = PH_CHECK;
            r = '0;
            r.out_kind     = KIND_PAYLOAD;
            r.payload_byte = b;
            r.status       = ST_OK;
            r.frame_length = fr_len;
            r.last         = 1'b0;
            due_beats.push_back(r);
         end
         PH_CHECK: begin
            due_beats.push_back(status_beat((b == fr_xor) ? ST_OK : ST_MISMATCH, fr_len));
            back_to_hunt();
         end
         default: back_to_hunt();
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic int unsigned draw_gap(input int unsigned mode);
      case (mode)
         IDLE_FULL:   return $urandom_range(0, 17);
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
         default:     return 0;
      endcase
   endfunction

   function automatic void add_byte(input logic [7:0] v);
      beat_type bt;
      bt.command = CMD_BYTE;
      bt.value   = v;
      bt.gap     = draw_gap(tx_mode);
      line_queue.push_back(bt);
      stim_total++;
   endfunction

   // The byte lane of a tick is don't-care; fill it with noise anyway.
   function automatic void add_tick(input logic counts);
      beat_type bt;
      bt.command = CMD_TICK;
      bt.value   = 8'($urandom_range(0, 255));
      bt.gap     = draw_gap(tx_mode);
      line_queue.push_back(bt);
      if (counts)
         stim_total++;
   endfunction

   // Queue one frame for the current settings: mostly well formed with random
   // content, sometimes preceded by line noise, with a broken sync pair, a bad
   // check byte, or abandoned mid-frame so that it times out.
   function automatic void add_frame();
      int unsigned lim;
      int unsigned n;
      int unsigned cut;
      int unsigned i;
      logic [7:0]  hi;
      logic [7:0]  v;
      logic [7:0]  sum;
      logic        aborted;
      lim = (fr_cfg.timeout_ticks == '0) ? 1 : int'(fr_cfg.timeout_ticks);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      // Ticks between frames land while hunting and must be ignored.
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 2)) add_tick(1'b0);
      add_byte(fr_cfg.header_first);
      // Only break the sync pair when a short timeout can realign the stream.
      if (lim <= 16 && $urandom_range(0, 19) == 0)
         add_byte(8'($urandom_range(0, 255)));
      else
         add_byte(fr_cfg.header_second);
      aborted = (lim <= 16) && ($urandom_range(0, 7) == 0);
      if (aborted && $urandom_range(0, 3) == 0) begin
         // Give up inside the length bytes.
         if ($urandom_range(0, 1) == 1)
            add_byte(8'($urandom_range(0, 255)));
         repeat (lim) add_tick(1'b1);
         return;
      end
      case ($urandom_range(0, 19))
         0:       n = 0;
         1, 2:    n = $urandom_range(9, 40);
         default: n = $urandom_range(1, 8);
      endcase
      // A huge announced length is only safe when the frame is abandoned.
      hi = (aborted && $urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'h00;
      add_byte(8'(n));
      add_byte(hi);
      if (n == 0 && hi == 8'h00)
         return;
      cut = aborted ? $urandom_range(0, n) : n + 1;
      sum = 8'h00;
      for (i = 0; i < n; i++) begin
         if (i == cut) begin
            repeat (lim) add_tick(1'b1);
            return;
         end
         v   = 8'($urandom_range(0, 255));
         sum = sum ^ v;
         add_byte(v);
         // Idle ticks short of the limit must not end the frame.
         if (lim > 1 && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, (lim > 4) ? 3 : lim - 1)) add_tick(1'b1);
      end
      if (aborted) begin
         // Stall in front of the check byte.
         repeat (lim) add_tick(1'b1);
         return;
      end
      if ($urandom_range(0, 4) == 0)
         add_byte(sum ^ 8'($urandom_range(1, 255)));
      else
         add_byte(sum);
   endfunction

   // Write one register and mirror it into the predicted settings.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TIMEOUT_W-1:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_HEADER_FIRST:  fr_cfg.header_first  = data[7:0];
         REG_HEADER_SECOND: fr_cfg.header_second = data[7:0];
         REG_TIMEOUT_TICKS: fr_cfg.timeout_ticks = data;
         default: ;
      endcase
   endtask

   // Program a full setting; the upper write bits of the sync registers are noise.
   task automatic apply_settings(input logic [7:0] h1, input logic [7:0] h2,
                                 input logic [TIMEOUT_W-1:0] tmo);
      csr_write(REG_HEADER_FIRST, {16'($urandom), h1});
      csr_write(REG_HEADER_SECOND, {16'($urandom), h2});
      csr_write(REG_TIMEOUT_TICKS, tmo);
      settings_used++;
      @(negedge clock);
   endtask

   // Hold the sender until the stream has drained and every result is back,
   // then allow the block's pipeline to settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (line_queue.size() != 0 || staged || req_bus.valid || due_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void field_check(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: feed req_ beats from line_queue, honoring each beat's gap.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.command    <= CMD_BYTE;
         req_bus.byte_value <= 8'h00;
         staged = 1'b0;
         back_to_hunt();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            deframe_step(on_bus.command, on_bus.value);
            beats_in++;
         end
         // Hold the current beat while the block stalls; otherwise advance.
         if (!req_bus.valid || req_bus.ready) begin
            if (!staged && line_queue.size() > 0) begin
               next_beat = line_queue.pop_front();
               staged    = 1'b1;
            end
            if (staged && next_beat.gap == 0) begin
               on_bus = next_beat;
               staged = 1'b0;
               req_bus.valid      <= 1'b1;
               req_bus.command    <= next_beat.command;
               req_bus.byte_value <= next_beat.value;
            end else begin
               if (staged)
                  next_beat.gap--;
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: take rsp_ beats with random stalls and compare them in order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_beats.size() == 0) begin
               $error("result beat with nothing expected: kind %0d byte 0x%0h status %0d",
                      rsp_bus.out_kind, rsp_bus.payload_byte, rsp_bus.status);
               errors++;
            end else begin
               want = due_beats.pop_front();
               results_seen++;
               if (want.out_kind == KIND_STATUS)
                  status_seen[want.status]++;
               else
                  payload_seen++;
               field_check("out_kind", 16'(want.out_kind), 16'(rsp_bus.out_kind));
               field_check("payload_byte", 16'(want.payload_byte), 16'(rsp_bus.payload_byte));
               field_check("status", 16'(want.status), 16'(rsp_bus.status));
               field_check("frame_length", want.frame_length, rsp_bus.frame_length);
               field_check("last", 16'(want.last), 16'(rsp_bus.last));
            end
            rx_wait = draw_gap(rx_mode);
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_bus.ready <= (rx_wait == 0) && (holdoff_left == 0);
      end
   end

   // Long receiver hold-off, started on request from the stimulus thread.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_done <= 0;
      end else if (holdoff_done != holdoff_reqs) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= holdoff_reqs;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Watchdog: abort a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int unsigned   phase_no;
      int            goal;
      logic [7:0]    h1;
      logic [7:0]    h2;
      logic [TIMEOUT_W-1:0] tmo;

      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_HEADER_FIRST;
      csr_bus.wdata      = '0;
      fr_cfg  = '{HEADER_FIRST_RESET, HEADER_SECOND_RESET, TIMEOUT_RESET};
      tx_mode = IDLE_SPARSE;
      rx_mode = IDLE_FULL;
      reset   = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: ticks while hunting, a sliding-window match after a
      // repeated first sync byte, a tick inside the payload, extreme payload
      // bytes with a good check, then a zero-length frame.
      settings_used = 1;
      add_tick(1'b0);
      add_byte(8'h5A);
      add_byte(8'h5A);
      add_byte(8'hA5);
      add_byte(8'h02);
      add_byte(8'h00);
      add_byte(8'h00);
      add_tick(1'b1);
      add_byte(8'hFF);
      add_byte(8'hFF);
      add_byte(8'h5A);
      add_byte(8'hA5);
      add_byte(8'h00);
      add_byte(8'h00);
      wait_idle();

      // Extreme sync bytes and a zero timeout register: the first tick of a
      // frame expires it. Cover the largest length and a timeout before the
      // length is complete; also poke the unused register index.
      tx_mode = IDLE_FULL;
      rx_mode = IDLE_SPARSE;
      csr_write(REG_SPARE, 24'($urandom));
      apply_settings(8'h00, 8'hFF, '0);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'hFF);
      add_byte(8'hFF);
      add_byte(8'hAA);
      add_tick(1'b1);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'h07);
      add_tick(1'b1);
      wait_idle();

      // Random frames, a fresh setting per phase; the sender drains fully
      // between phases before the registers change.
      phase_no = 0;
      while (stim_total < ITEM_TARGET) begin
         case (phase_no)
            0: begin
               // Equal sync bytes and the largest timeout.
               h1 = 8'hFF;
               h2 = 8'hFF;
               tmo = '1;
               tx_mode = IDLE_NONE;
               rx_mode = IDLE_FULL;
            end
            1: begin
               // Back-to-back beats against a long receiver hold-off.
               h1 = 8'($urandom_range(0, 255));
               h2 = 8'($urandom_range(0, 255));
               tmo = 24'd3;
               tx_mode = IDLE_NONE;
               rx_mode = IDLE_SPARSE;
            end
            2: begin
               h1 = 8'($urandom_range(0, 255));
               h2 = 8'($urandom_range(0, 255));
               tmo = 24'd1;
               tx_mode = IDLE_FULL;
               rx_mode = IDLE_NONE;
            end
            default: begin
               h1 = 8'($urandom_range(0, 255));
               h2 = ($urandom_range(0, 4) == 0) ? h1 : 8'($urandom_range(0, 255));
               case ($urandom_range(0, 5))
                  0:       tmo = '0;
                  1:       tmo = TIMEOUT_RESET;
                  2:       tmo = 24'd1;
                  default: tmo = 24'($urandom_range(2, 12));
               endcase
               tx_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
               rx_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            end
         endcase
         apply_settings(h1, h2, tmo);
         goal = stim_total + PHASE_ITEMS;
         while (stim_total < goal)
            add_frame();
         if (phase_no == 1) begin
            @(posedge clock);
            holdoff_reqs <= holdoff_reqs + 1;
         end
         wait_idle();
         phase_no++;
      end

      $display("Sent %0d input beats; checked %0d result beats (%0d payload)",
               beats_in, results_seen, payload_seen);
      $display("under %0d settings. Frame endings: %0d ok, %0d checksum mismatch,",
               settings_used, status_seen[ST_OK], status_seen[ST_MISMATCH]);
      $display("%0d zero length, %0d timeout.",
               status_seen[ST_ZERO_LEN], status_seen[ST_TIMEOUT]);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
